[design/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define CHECK_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// next-cycle implication, off while reset is high
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

[design/tcaq_pkg.sv]
// shared types, constants and helpers of the two-class age-ordered queue
`timescale 1ns / 1ps

package tcaq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS    = 16;

   // field widths of the word ports
   localparam int TAG_W   = 16;
   localparam int STAMP_W = 32;

   // tag bits actually kept in the stores
   localparam int KEEP_W  = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = KEEP_W + STAMP_W;

   typedef enum logic [1:0] {
      OP_ENQ     = 2'd0,
      OP_DEQ_ANY = 2'd1,
      OP_DEQ0    = 2'd2,
      OP_DEQ1    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_EXEC,
      STATE_RESP
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic execute;
   } cmd_type;

   // circular pointer step
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + 1'b1;
      end
      return result;
   endfunction

endpackage

[design/two_class_age_ordered_queue_top.sv]
// top level of the two-class age-ordered queue
//
// Usage: one request word on the req_ channel carries an operation
// (enqueue, dequeue any, dequeue class 0, dequeue class 1), a class and
// a tag. Every request gives exactly one response word on the rsp_
// channel with a status, class, tag and arrival stamp.
// Dequeue any returns the head with the older arrival stamp.
// Timing: an accepted request is held in the request capture register,
// executed from there into the response register, and its response is
// valid from then on until taken. The block holds one request at a time:
// req_stall is high from the accept until the response is taken, so a word
// passes through capture, execute and response in turn. The store read
// ports already hold the head entries when a request is taken.
// Reset (synchronous, active high) empties both queues and clears the
// arrival counter; store contents are not cleared and need no sweep.
// While rsp_stall is high the response word holds and no new request
// is accepted.
`timescale 1ns / 1ps

module two_class_age_ordered_queue_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic                         req_kind,
   input  logic [tcaq_pkg::TAG_W-1:0]   req_tag,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_out_kind,
   output logic [tcaq_pkg::TAG_W-1:0]   rsp_out_tag,
   output logic [tcaq_pkg::STAMP_W-1:0] rsp_stamp
);
   import tcaq_pkg::*;

   cmd_type cmd;

   // sequencing
   tcaq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // queues and response word
   tcaq_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_op       (req_op),
      .req_kind     (req_kind),
      .req_tag      (req_tag),
      .rsp_status   (rsp_status),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_tag  (rsp_out_tag),
      .rsp_stamp    (rsp_stamp)
   );

endmodule

[design/tcaq_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tcaq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tcaq_ctrl.sv]
// controller: sequences accept, execute and response of one word
`timescale 1ns / 1ps

module tcaq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcaq_pkg::cmd_type cmd
);
   import tcaq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         STATE_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = STATE_RESP;
         end
         STATE_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

endmodule

[design/tcaq_dp.sv]
// datapath: queue stores, pointers, arrival counter and response registers
`timescale 1ns / 1ps

module tcaq_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  tcaq_pkg::cmd_type               cmd,
   input  logic [1:0]                      req_op,
   input  logic                            req_kind,
   input  logic [tcaq_pkg::TAG_W-1:0]      req_tag,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_out_kind,
   output logic [tcaq_pkg::TAG_W-1:0]      rsp_out_tag,
   output logic [tcaq_pkg::STAMP_W-1:0]    rsp_stamp
);
   import tcaq_pkg::*;

   // captured request word
   op_type             op_ff;
   logic               kind_ff;
   logic [KEEP_W-1:0]  tag_ff;

   // queue bookkeeping, one slot per class
   logic [PTR_W-1:0]   head_ff  [2];
   logic [PTR_W-1:0]   head_in  [2];
   logic [PTR_W-1:0]   tail_ff  [2];
   logic [PTR_W-1:0]   tail_in  [2];
   logic [CNT_W-1:0]   count_ff [2];
   logic [CNT_W-1:0]   count_in [2];
   logic [STAMP_W-1:0] arrival_ff;
   logic [STAMP_W-1:0] arrival_in;

   // response word
   status_type         rsp_status_ff;
   status_type         rsp_status_in;
   logic               rsp_kind_ff;
   logic               rsp_kind_in;
   logic [TAG_W-1:0]   rsp_tag_ff;
   logic [TAG_W-1:0]   rsp_tag_in;
   logic [STAMP_W-1:0] rsp_stamp_ff;
   logic [STAMP_W-1:0] rsp_stamp_in;

   // store ports
   logic [1:0]         wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data  [2];
   logic [KEEP_W-1:0]  rd_tag   [2];
   logic [STAMP_W-1:0] rd_stamp [2];
   logic [1:0]         empty;
   logic [STAMP_W-1:0] age_diff;
   logic               take0;

   assign wr_data = {tag_ff, arrival_ff};

   // one store per class, read continuously at its head
   for (genvar c = 0; c < 2; c++) begin : g_store
      tcaq_ram #(
         .WIDTH (ENTRY_W),
         .DEPTH (QUEUE_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[c]),
         .wr_addr (tail_ff[c]),
         .wr_data (wr_data),
         .rd_addr (head_ff[c]),
         .rd_data (rd_data[c])
      );
      assign rd_tag[c]   = rd_data[c][ENTRY_W-1:STAMP_W];
      assign rd_stamp[c] = rd_data[c][STAMP_W-1:0];
      assign empty[c]    = (count_ff[c] == '0);
   end

   // older head by modular stamp difference, ties go to class 1
   assign age_diff = rd_stamp[1] - rd_stamp[0];
   assign take0    = (age_diff != '0) && !age_diff[STAMP_W-1];

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= op_type'(req_op);
         kind_ff <= req_kind;
         tag_ff  <= req_tag[KEEP_W-1:0];
      end
   end

   // execute one operation
   always_comb begin
      logic pop;
      logic sel;
      pop           = 1'b0;
      sel           = 1'b0;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      arrival_in    = arrival_ff;
      wr_en         = '0;
      rsp_status_in = rsp_status_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      if (cmd.execute) begin
         case (op_ff)
            OP_ENQ: begin
               rsp_kind_in  = kind_ff;
               rsp_tag_in   = TAG_W'(tag_ff);
               rsp_stamp_in = arrival_ff;
               if (count_ff[kind_ff] >= CNT_W'(QUEUE_DEPTH)) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  rsp_status_in     = STATUS_OK;
                  wr_en[kind_ff]    = 1'b1;
                  tail_in[kind_ff]  = ptr_next(tail_ff[kind_ff]);
                  count_in[kind_ff] = count_ff[kind_ff] + 1'b1;
                  arrival_in        = arrival_ff + 1'b1;
               end
            end
            OP_DEQ_ANY: begin
               if (empty[0] && empty[1]) begin
                  rsp_status_in = STATUS_EMPTY;
                  rsp_kind_in   = 1'b0;
                  rsp_tag_in    = '0;
                  rsp_stamp_in  = '0;
               end else begin
                  pop = 1'b1;
                  if (empty[0]) begin
                     sel = 1'b1;
                  end else if (empty[1]) begin
                     sel = 1'b0;
                  end else begin
                     sel = !take0;
                  end
               end
            end
            OP_DEQ0: begin
               pop = 1'b1;
               sel = 1'b0;
            end
            OP_DEQ1: begin
               pop = 1'b1;
               sel = 1'b1;
            end
            default: begin
               pop = 1'b0;
            end
         endcase
         // pop the selected class, or report it empty
         if (pop) begin
            rsp_kind_in = sel;
            if (empty[sel]) begin
               rsp_status_in = STATUS_EMPTY;
               rsp_tag_in    = '0;
               rsp_stamp_in  = '0;
            end else begin
               rsp_status_in = STATUS_OK;
               rsp_tag_in    = TAG_W'(rd_tag[sel]);
               rsp_stamp_in  = rd_stamp[sel];
               head_in[sel]  = ptr_next(head_ff[sel]);
               count_in[sel] = count_ff[sel] - 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '{default: '0};
         tail_ff    <= '{default: '0};
         count_ff   <= '{default: '0};
         arrival_ff <= '0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         arrival_ff <= arrival_in;
      end
   end

   // response registers
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_stamp_ff  <= rsp_stamp_in;
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_out_kind = rsp_kind_ff;
   assign rsp_out_tag  = rsp_tag_ff;
   assign rsp_stamp    = rsp_stamp_ff;

endmodule

[design/tcaq_checker.sv]
// port-level checks of the two-class age-ordered queue, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcaq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_status,
   input logic                         rsp_out_kind,
   input logic [tcaq_pkg::TAG_W-1:0]   rsp_out_tag,
   input logic [tcaq_pkg::STAMP_W-1:0] rsp_stamp
);
   import tcaq_pkg::*;

   // a word is taken only while no response is pending
   `CHECK_NOW(a_accept_idle, clock, reset, req_valid && !req_stall, !rsp_valid)

   // once a word is taken the input side closes until its response is done
   `CHECK_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall && !rsp_valid)

   // an empty report carries no tag or stamp
   `CHECK_NOW(a_empty_clean, clock, reset, rsp_valid && (rsp_status == STATUS_EMPTY), (rsp_out_tag == '0) && (rsp_stamp == '0))

   // a stalled response holds
   `CHECK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_out_tag) && $stable(rsp_stamp) && $stable(rsp_out_kind))

endmodule

bind two_class_age_ordered_queue_top tcaq_checker u_checker (.*);
